// ===== rtl/arx_ks_pkg.sv =====
// ----------------------------------------------------------------------------
// arx_ks_pkg
// Shared types, constants and the quarter-round datapath for the ARX
// keystream core.
// ----------------------------------------------------------------------------
`default_nettype none

package arx_ks_pkg;

  localparam int WORD_W         = 32;
  localparam int BLOCK_WORDS    = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int MAIN_ROUNDS_D  = 20;
  localparam int EXTRA_ROUNDS_D = 3;

  localparam logic [WORD_W-1:0] BLOCK_CONST = 32'h4368_6143;

  typedef logic [WORD_W-1:0]                   word_t;
  typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0]  block_t;
  typedef logic [3:0][WORD_W-1:0]              quad_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_NONCE = 3'd4
  } cfg_idx_t;

  // Round engine states
  typedef enum logic [1:0] {
    GS_IDLE,
    GS_RUN,
    GS_LAST
  } gen_state_t;

  // Controls into the round engine
  typedef struct packed {
    logic start;
    logic abort;
  } gen_ctl_t;

  // Status out of the round engine
  typedef struct packed {
    logic busy;
    logic done;
    logic wr_en;
  } gen_stat_t;

  // One half of a quarter-round: rotations 16/12 for the first half,
  // 8/7 for the second. Result element 0..3 is a, b, c, d.
  function automatic quad_t qr_half(input word_t a, input word_t b,
                                    input word_t c, input word_t d,
                                    input logic second);
    word_t a1;
    word_t dx;
    word_t d1;
    word_t c1;
    word_t bx;
    word_t b1;
    a1 = a + b;
    dx = d ^ a1;
    d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    c1 = c + d1;
    bx = b ^ c1;
    b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
    return {d1, c1, b1, a1};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/arx_ks_ram.sv =====
// ----------------------------------------------------------------------------
// arx_ks_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_ks_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arx_ks_gen.sv =====
// ----------------------------------------------------------------------------
// arx_ks_gen
// Round engine: runs the double rounds on the 8-word state, one half
// quarter-round step per cycle, and emits state XOR block as one wide
// keystream group after each of the final double rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_ks_gen #(
  parameter int MAIN_ROUNDS         = arx_ks_pkg::MAIN_ROUNDS_D,
  parameter int EXTRA_DOUBLE_ROUNDS = arx_ks_pkg::EXTRA_ROUNDS_D,
  localparam int GROUPS = EXTRA_DOUBLE_ROUNDS + 1,
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire arx_ks_pkg::gen_ctl_t              ctl,
  input  wire logic [3:0][arx_ks_pkg::WORD_W-1:0] key,
  input  wire logic [arx_ks_pkg::CFG_DATA_W-1:0] nonce,
  input  wire arx_ks_pkg::word_t                 ctr,
  output arx_ks_pkg::gen_stat_t                  stat,
  output logic [GW-1:0]                          wr_grp,
  output arx_ks_pkg::block_t                     wr_data
);

  localparam int DR    = (MAIN_ROUNDS + 1) / 2;
  localparam int TOTAL = DR + EXTRA_DOUBLE_ROUNDS;
  localparam int RW    = $clog2(TOTAL + 1);

  arx_ks_pkg::gen_state_t state;
  arx_ks_pkg::gen_state_t state_next;

  arx_ks_pkg::block_t st;
  arx_ks_pkg::block_t st_next;
  arx_ks_pkg::block_t blk;
  logic [RW-1:0]      round;
  logic [RW-1:0]      round_p1;
  logic [1:0]         phase;
  logic               wr_pend;
  logic               round_end;
  logic               last_round;
  arx_ks_pkg::quad_t  q0;
  arx_ks_pkg::quad_t  q1;

  assign round_p1   = round + RW'(1);
  assign round_end  = (phase == 2'd3);
  assign last_round = round_end && (round_p1 == RW'(TOTAL));

  // One half-step of two independent quarter-rounds: columns, then diagonals
  always_comb begin
    st_next = st;
    if (!phase[1]) begin
      q0 = arx_ks_pkg::qr_half(st[0], st[1], st[2], st[3], phase[0]);
      q1 = arx_ks_pkg::qr_half(st[4], st[5], st[6], st[7], phase[0]);
      st_next[0] = q0[0];
      st_next[1] = q0[1];
      st_next[2] = q0[2];
      st_next[3] = q0[3];
      st_next[4] = q1[0];
      st_next[5] = q1[1];
      st_next[6] = q1[2];
      st_next[7] = q1[3];
    end else begin
      q0 = arx_ks_pkg::qr_half(st[0], st[5], st[2], st[7], phase[0]);
      q1 = arx_ks_pkg::qr_half(st[1], st[6], st[3], st[4], phase[0]);
      st_next[0] = q0[0];
      st_next[5] = q0[1];
      st_next[2] = q0[2];
      st_next[7] = q0[3];
      st_next[1] = q1[0];
      st_next[6] = q1[1];
      st_next[3] = q1[2];
      st_next[4] = q1[3];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      arx_ks_pkg::GS_IDLE: begin
        if (ctl.start && !ctl.abort) state_next = arx_ks_pkg::GS_RUN;
      end
      arx_ks_pkg::GS_RUN: begin
        if (ctl.abort)       state_next = arx_ks_pkg::GS_IDLE;
        else if (last_round) state_next = arx_ks_pkg::GS_LAST;
      end
      arx_ks_pkg::GS_LAST: begin
        state_next = arx_ks_pkg::GS_IDLE;
      end
      default: state_next = arx_ks_pkg::GS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    stat.busy  = 1'b0;
    stat.done  = 1'b0;
    stat.wr_en = 1'b0;
    unique case (state)
      arx_ks_pkg::GS_IDLE: begin
        stat.busy = 1'b0;
      end
      arx_ks_pkg::GS_RUN: begin
        stat.busy  = 1'b1;
        stat.wr_en = wr_pend;
      end
      arx_ks_pkg::GS_LAST: begin
        stat.busy  = 1'b1;
        stat.done  = 1'b1;
        stat.wr_en = wr_pend;
      end
      default: stat.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arx_ks_pkg::GS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Round and phase counters; flag a group write after each final round
  always_ff @(posedge clk) begin
    if (rst) begin
      round   <= '0;
      phase   <= '0;
      wr_pend <= 1'b0;
    end else if (ctl.abort) begin
      wr_pend <= 1'b0;
    end else if (state == arx_ks_pkg::GS_IDLE) begin
      round   <= '0;
      phase   <= '0;
      wr_pend <= 1'b0;
    end else if (state == arx_ks_pkg::GS_RUN) begin
      phase   <= phase + 2'd1;
      wr_pend <= round_end && (round_p1 >= RW'(DR));
      if (round_end) begin
        round <= round_p1;
      end
    end else begin
      wr_pend <= 1'b0;
    end
  end

  // Load the block at start, advance the state while running
  always_ff @(posedge clk) begin
    if (state == arx_ks_pkg::GS_IDLE && ctl.start) begin
      blk[0] <= key[0];
      blk[1] <= key[1];
      blk[2] <= key[2];
      blk[3] <= key[3];
      blk[4] <= ctr;
      blk[5] <= nonce[63:32];
      blk[6] <= nonce[31:0];
      blk[7] <= arx_ks_pkg::BLOCK_CONST;
      st[0]  <= key[0];
      st[1]  <= key[1];
      st[2]  <= key[2];
      st[3]  <= key[3];
      st[4]  <= ctr;
      st[5]  <= nonce[63:32];
      st[6]  <= nonce[31:0];
      st[7]  <= arx_ks_pkg::BLOCK_CONST;
    end else if (state == arx_ks_pkg::GS_RUN) begin
      st <= st_next;
    end
  end

  // Group index of the pending write
  always_ff @(posedge clk) begin
    if (state == arx_ks_pkg::GS_RUN && round_end) begin
      wr_grp <= GW'(round_p1 - RW'(DR));
    end
  end

  assign wr_data = st ^ blk;

endmodule

`default_nettype wire

// ===== rtl/arx_ks_top_ctl.sv =====
// ----------------------------------------------------------------------------
// arx_ks_top_ctl
// Keystream bank control and data path: keeps the configuration registers,
// the block counter and word position, tracks which of two keystream banks
// is full, and XORs each data beat with its keystream word read from RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_ks_top_ctl #(
  parameter int MAIN_ROUNDS         = arx_ks_pkg::MAIN_ROUNDS_D,
  parameter int EXTRA_DOUBLE_ROUNDS = arx_ks_pkg::EXTRA_ROUNDS_D
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [arx_ks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [arx_ks_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                               data_valid,
  output logic                                    data_stall,
  input  wire logic [arx_ks_pkg::WORD_W-1:0]      data_word,
  output logic                                    cipher_valid,
  input  wire logic                               cipher_stall,
  output logic [arx_ks_pkg::WORD_W-1:0]           cipher_word
);

  localparam int GROUPS = EXTRA_DOUBLE_ROUNDS + 1;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int DEPTH  = 2 * GROUPS;
  localparam int AW     = $clog2(DEPTH);
  localparam int KS_LEN = arx_ks_pkg::BLOCK_WORDS * GROUPS;
  localparam int PW     = $clog2(KS_LEN);
  localparam int RAM_W  = arx_ks_pkg::BLOCK_WORDS * arx_ks_pkg::WORD_W;
  localparam logic [AW-1:0] BANK_OFS = AW'(GROUPS);

  // Configuration registers
  logic [3:0][arx_ks_pkg::WORD_W-1:0] key;
  logic [arx_ks_pkg::CFG_DATA_W-1:0]  nonce;

  // Consumer side
  arx_ks_pkg::word_t blk_ctr;
  logic [PW-1:0]     pos;
  logic              rd_bank;
  logic [1:0]        full;
  logic              in_accept;
  logic              s1_adv;
  logic              s1_v;
  arx_ks_pkg::word_t s1_data;
  logic [2:0]        s1_sel;
  logic              last_word;

  // Producer side
  arx_ks_pkg::word_t     gen_ctr;
  logic                  wr_bank;
  arx_ks_pkg::gen_ctl_t  gen_ctl;
  arx_ks_pkg::gen_stat_t gen_stat;
  logic [GW-1:0]         gen_grp;
  arx_ks_pkg::block_t    gen_data;

  // RAM ports
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [RAM_W-1:0]   rd_raw;
  arx_ks_pkg::block_t rd_words;

  // Handshake
  assign s1_adv     = !cipher_valid || !cipher_stall;
  assign data_stall = (s1_v && !s1_adv) || cfg_we ||
                      ((pos == '0) && !full[rd_bank]);
  assign in_accept  = data_valid && !data_stall;
  assign last_word  = (pos == PW'(KS_LEN - 1));

  // Start a new block whenever the engine is free, its bank is empty and no config write is under way
  assign gen_ctl.start = !gen_stat.busy && !full[wr_bank] && !cfg_we;
  assign gen_ctl.abort = cfg_we;

  assign wr_addr  = (wr_bank ? BANK_OFS : '0) + AW'(gen_grp);
  assign rd_addr  = (rd_bank ? BANK_OFS : '0) + AW'(pos >> 3);
  assign rd_words = rd_raw;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= '0;
      nonce <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        arx_ks_pkg::CFG_KEY0:  key[0] <= cfg_data[31:0];
        arx_ks_pkg::CFG_KEY1:  key[1] <= cfg_data[31:0];
        arx_ks_pkg::CFG_KEY2:  key[2] <= cfg_data[31:0];
        arx_ks_pkg::CFG_KEY3:  key[3] <= cfg_data[31:0];
        arx_ks_pkg::CFG_NONCE: nonce  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bank bookkeeping: a config write drops every bank not in use and
  // restarts generation from the current block counter
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_ctr <= '0;
      pos     <= '0;
      rd_bank <= 1'b0;
      wr_bank <= 1'b0;
      full    <= '0;
      gen_ctr <= '0;
    end else if (cfg_we) begin
      gen_ctr <= blk_ctr;
      if (pos == '0) begin
        full    <= '0;
        wr_bank <= rd_bank;
      end else begin
        full[!rd_bank] <= 1'b0;
        wr_bank        <= !rd_bank;
      end
    end else begin
      if (gen_ctl.start) begin
        gen_ctr <= gen_ctr + 32'd1;
      end
      if (gen_stat.done) begin
        full[wr_bank] <= 1'b1;
        wr_bank       <= !wr_bank;
      end
      if (in_accept) begin
        if (pos == '0) begin
          blk_ctr <= blk_ctr + 32'd1;
        end
        if (last_word) begin
          pos           <= '0;
          full[rd_bank] <= 1'b0;
          rd_bank       <= !rd_bank;
        end else begin
          pos <= pos + PW'(1);
        end
      end
    end
  end

  // Stage 1: hold the data beat while the keystream group is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_accept) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data <= data_word;
      s1_sel  <= pos[2:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_valid <= 1'b0;
    end else if (s1_adv) begin
      cipher_valid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v) begin
      cipher_word <= s1_data ^ rd_words[s1_sel];
    end
  end

  arx_ks_gen #(
    .MAIN_ROUNDS         (MAIN_ROUNDS),
    .EXTRA_DOUBLE_ROUNDS (EXTRA_DOUBLE_ROUNDS)
  ) u_gen (
    .clk     (clk),
    .rst     (rst),
    .ctl     (gen_ctl),
    .key     (key),
    .nonce   (nonce),
    .ctr     (gen_ctr),
    .stat    (gen_stat),
    .wr_grp  (gen_grp),
    .wr_data (gen_data)
  );

  arx_ks_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (gen_stat.wr_en),
    .wr_addr (wr_addr),
    .wr_data (gen_data),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

endmodule

`default_nettype wire

// ===== rtl/arx_keystream_stream_cipher_core.sv =====
// Datapath: an accepted data beat waits in the stage-1 register while its
//   keystream group is read from RAM, then passes the output register to cipher_word.
// Keystream: each block of 8*(EXTRA_DOUBLE_ROUNDS+1) keystream words is generated
//   into one of two RAM banks while the other bank is still being consumed.
// Reset: clears registers, counter and bank flags; the first block is then
//   generated before the first data beat is taken.
// ----------------------------------------------------------------------------
// arx_keystream_stream_cipher_core
// Reduced 8-word ARX stream cipher: XORs each data word with the next
// keystream word.
// ----------------------------------------------------------------------------
`default_nettype none

module arx_keystream_stream_cipher_core #(
  parameter int MAIN_ROUNDS         = arx_ks_pkg::MAIN_ROUNDS_D,
  parameter int EXTRA_DOUBLE_ROUNDS = arx_ks_pkg::EXTRA_ROUNDS_D
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [arx_ks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [arx_ks_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                               data_valid,
  output logic                                    data_stall,
  input  wire logic [arx_ks_pkg::WORD_W-1:0]      data_word,
  output logic                                    cipher_valid,
  input  wire logic                               cipher_stall,
  output logic [arx_ks_pkg::WORD_W-1:0]           cipher_word
);

  arx_ks_top_ctl #(
    .MAIN_ROUNDS         (MAIN_ROUNDS),
    .EXTRA_DOUBLE_ROUNDS (EXTRA_DOUBLE_ROUNDS)
  ) u_ctl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_word    (data_word),
    .cipher_valid (cipher_valid),
    .cipher_stall (cipher_stall),
    .cipher_word  (cipher_word)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARX keystream cipher core testbench
// Drives data words through the core under changing key and nonce settings,
// predicts every cipher word with an independent keystream model, and checks
// the output stream in order under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAIN_DOUBLE = (arx_ks_pkg::MAIN_ROUNDS_D + 1) / 2;
  localparam int BLK_WORDS   = arx_ks_pkg::BLOCK_WORDS;
  localparam int EXTRA_DR    = arx_ks_pkg::EXTRA_ROUNDS_D;
  localparam int KS_WORDS    = BLK_WORDS * (1 + EXTRA_DR);
  localparam int LAST_INDEX  = (1 << arx_ks_pkg::CFG_IDX_W) - 1;
  localparam int NONCE_INDEX = int'(arx_ks_pkg::CFG_NONCE);
  localparam int KEY0_INDEX  = int'(arx_ks_pkg::CFG_KEY0);
  localparam int KEY3_INDEX  = int'(arx_ks_pkg::CFG_KEY3);
  localparam int HOLD_CYCLES = 200;

  typedef logic [arx_ks_pkg::CFG_IDX_W-1:0]  idx_t;
  typedef logic [arx_ks_pkg::CFG_DATA_W-1:0] cfg_val_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  idx_t              cfg_index;
  cfg_val_t          cfg_data;
  logic              data_valid;
  logic              data_stall;
  arx_ks_pkg::word_t data_word;
  logic              cipher_valid;
  logic              cipher_stall;
  arx_ks_pkg::word_t cipher_word;

  // Keystream predictor state
  arx_ks_pkg::word_t key_reg [4];
  cfg_val_t          nonce_reg;
  arx_ks_pkg::word_t block_count;
  int                word_pos;
  arx_ks_pkg::word_t ks_words [KS_WORDS];
  arx_ks_pkg::word_t ks_state [BLK_WORDS];
  arx_ks_pkg::word_t ks_block [BLK_WORDS];
  arx_ks_pkg::word_t expected_cipher_q [$];

  int mismatches;
  int beats_checked;
  int blocks_built;
  int settings_used;
  bit idle_en;
  int hold_req;

  arx_keystream_stream_cipher_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_word    (data_word),
    .cipher_valid (cipher_valid),
    .cipher_stall (cipher_stall),
    .cipher_word  (cipher_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("arx_keystream_stream_cipher_core verification failed");
    $finish;
  end

  function automatic arx_ks_pkg::word_t rotl(arx_ks_pkg::word_t v, int s);
    return (v << s) | (v >> (arx_ks_pkg::WORD_W - s));
  endfunction

  function automatic void quarter_mix(int a, int b, int c, int d);
    ks_state[a] = ks_state[a] + ks_state[b];
    ks_state[d] = rotl(ks_state[d] ^ ks_state[a], 16);
    ks_state[c] = ks_state[c] + ks_state[d];
    ks_state[b] = rotl(ks_state[b] ^ ks_state[c], 12);
    ks_state[a] = ks_state[a] + ks_state[b];
    ks_state[d] = rotl(ks_state[d] ^ ks_state[a], 8);
    ks_state[c] = ks_state[c] + ks_state[d];
    ks_state[b] = rotl(ks_state[b] ^ ks_state[c], 7);
  endfunction

  // Columns, then diagonals
  function automatic void double_mix();
    quarter_mix(0, 1, 2, 3);
    quarter_mix(4, 5, 6, 7);
    quarter_mix(0, 5, 2, 7);
    quarter_mix(1, 6, 3, 4);
  endfunction

  // Build one keystream buffer from key, counter, nonce and constant
  function automatic void build_keystream();
    for (int j = 0; j < 4; j++) ks_block[j] = key_reg[j];
    ks_block[4] = block_count;
    ks_block[5] = nonce_reg[63:32];
    ks_block[6] = nonce_reg[31:0];
    ks_block[7] = arx_ks_pkg::BLOCK_CONST;
    ks_state = ks_block;
    for (int r = 0; r < MAIN_DOUBLE; r++) double_mix();
    for (int r = 0; r <= EXTRA_DR; r++) begin
      if (r > 0) double_mix();
      for (int j = 0; j < BLK_WORDS; j++)
        ks_words[BLK_WORDS * r + j] = ks_state[j] ^ ks_block[j];
    end
  endfunction

  // Advance the predictor by one data word
  function automatic arx_ks_pkg::word_t encrypt_word(arx_ks_pkg::word_t w);
    arx_ks_pkg::word_t k;
    if (word_pos == 0) begin
      build_keystream();
      block_count = block_count + 1'b1;
      blocks_built++;
    end
    k = ks_words[word_pos];
    word_pos = (word_pos + 1) % KS_WORDS;
    return w ^ k;
  endfunction

  // Mirror a register write; keys keep the low word, unknown indexes drop
  function automatic void load_register(idx_t idx, cfg_val_t val);
    if (idx < arx_ks_pkg::CFG_NONCE) key_reg[idx[1:0]] = val[arx_ks_pkg::WORD_W-1:0];
    else if (idx == arx_ks_pkg::CFG_NONCE) nonce_reg = val;
  endfunction

  function automatic arx_ks_pkg::word_t pick_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfg_val_t pick_setting();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_register(idx_t idx, cfg_val_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    load_register(idx, val);
  endtask

  // Offer one beat, optionally after a gap, and record its expected cipher word
  task automatic send_word(arx_ks_pkg::word_t w);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_valid <= 1'b1;
    data_word  <= w;
    do @(posedge clk); while (data_stall);
    expected_cipher_q.push_back(encrypt_word(w));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    data_valid <= 1'b0;
  endtask

  // Wait for every expected beat, then let the pipeline settle
  task automatic wait_drained();
    while (expected_cipher_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_word('0);
    send_word('1);
    send_word(32'hA5A5_5A5A);
    send_word(32'h5A5A_A5A5);
    send_word(32'h0000_0001);
    send_word(32'h8000_0000);
    drop_valid();
    wait_drained();
  endtask

  // All-ones and mixed extremes; high bits above a key word must be masked
  task automatic test_register_extremes();
    for (int i = KEY0_INDEX; i <= KEY3_INDEX; i++) write_register(idx_t'(i), '1);
    write_register(arx_ks_pkg::CFG_NONCE, '1);
    settings_used++;
    repeat (4) send_word(pick_word());
    drop_valid();
    wait_drained();
    for (int i = KEY0_INDEX; i <= KEY3_INDEX; i++)
      write_register(idx_t'(i), 64'hFFFF_FFFF_0000_0000);
    write_register(arx_ks_pkg::CFG_NONCE, 64'h8000_0000_0000_0001);
    settings_used++;
    repeat (4) send_word(pick_word());
    drop_valid();
    wait_drained();
  endtask

  // Writes above the last register must leave the keystream alone
  task automatic test_ignored_indexes();
    for (int i = NONCE_INDEX + 1; i <= LAST_INDEX; i++)
      write_register(idx_t'(i), {$urandom, $urandom});
    repeat (4) send_word(pick_word());
    drop_valid();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int n;
    idle_en = 1'b1;
    repeat (6) begin
      for (int i = KEY0_INDEX; i <= NONCE_INDEX; i++)
        if ($urandom_range(0, 1)) write_register(idx_t'(i), pick_setting());
      if ($urandom_range(0, 3) == 0)
        write_register(idx_t'($urandom_range(NONCE_INDEX + 1, LAST_INDEX)),
                       {$urandom, $urandom});
      settings_used++;
      n = $urandom_range(30, 80);
      repeat (n) send_word(pick_word());
      drop_valid();
      wait_drained();
    end
  endtask

  // Hold the output long enough that the core backs up into its input
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    repeat (40) send_word(pick_word());
    drop_valid();
    wait_drained();
  endtask

  // Back-to-back beats across several keystream blocks, no idling
  task automatic test_streaming();
    idle_en = 1'b0;
    for (int i = KEY0_INDEX; i <= NONCE_INDEX; i++)
      write_register(idx_t'(i), {$urandom, $urandom});
    settings_used++;
    repeat (70) send_word(pick_word());
    drop_valid();
    wait_drained();
  endtask

  // Output side: long hold-off on request, otherwise random stall bursts while idle_en is set
  initial begin
    int stall_left;
    stall_left   = 0;
    cipher_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        cipher_stall <= 1'b1;
        hold_req--;
      end else if (stall_left > 0) begin
        cipher_stall <= 1'b1;
        stall_left--;
      end else begin
        cipher_stall <= 1'b0;
        if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  // Compare each output beat with the oldest expected cipher word
  always @(posedge clk) begin
    arx_ks_pkg::word_t exp_word;
    if (!rst && cipher_valid && !cipher_stall) begin
      if (expected_cipher_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected cipher beat: expected none actual %08h", $time, cipher_word);
      end else begin
        exp_word = expected_cipher_q.pop_front();
        beats_checked++;
        if (cipher_word !== exp_word) begin
          mismatches++;
          $display("%0t: cipher_word mismatch: expected %08h actual %08h",
                   $time, exp_word, cipher_word);
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    data_valid = 1'b0;
    data_word  = '0;
    idle_en    = 1'b1;
    hold_req   = 0;
    mismatches = 0;
    beats_checked = 0;
    blocks_built  = 0;
    settings_used = 1;
    for (int j = 0; j < 4; j++) key_reg[j] = '0;
    nonce_reg   = '0;
    block_count = '0;
    word_pos    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_ignored_indexes();
    test_random_traffic();
    test_backpressure();
    test_streaming();

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_cipher_q.size() != 0) mismatches++;
    $display("Run covered %0d cipher beats over %0d keystream blocks and %0d key/nonce settings,",
             beats_checked, blocks_built, settings_used);
    $display("with masked key bits, ignored register indexes, output hold-off and full-rate bursts.");
    if (mismatches == 0) begin
      $display("arx_keystream_stream_cipher_core verification clean");
    end else begin
      $display("arx_keystream_stream_cipher_core verification failed");
    end
    $finish;
  end

endmodule
